// ===== hw/rtl/htu_pkg.sv =====
package htu_pkg;

  localparam int unsigned LOCAL_IRQ_BASE = 16;

  localparam logic [63:0] LOCAL_MASK   = {64{1'b1}} << LOCAL_IRQ_BASE;
  localparam logic [63:0] STD_IRQ_MASK = 64'h0000_0000_0000_0AAA;

  localparam logic [1:0] PRIV_U = 2'd0;
  localparam logic [1:0] PRIV_S = 2'd1;
  localparam logic [1:0] PRIV_M = 2'd3;

  localparam int unsigned SIE_BIT  = 1;
  localparam int unsigned MIE_BIT  = 3;
  localparam int unsigned SPIE_BIT = 5;
  localparam int unsigned MPIE_BIT = 7;
  localparam int unsigned SPP_BIT  = 8;
  localparam int unsigned MPP_LO   = 11;
  localparam int unsigned MPP_HI   = 12;

  localparam logic [5:0] IRQ_SSI = 6'd1;
  localparam logic [5:0] IRQ_MSI = 6'd3;
  localparam logic [5:0] IRQ_STI = 6'd5;
  localparam logic [5:0] IRQ_MTI = 6'd7;
  localparam logic [5:0] IRQ_SEI = 6'd9;
  localparam logic [5:0] IRQ_MEI = 6'd11;

  localparam logic [1:0] CFG_INT_DELEG = 2'd0;
  localparam logic [1:0] CFG_EXC_DELEG = 2'd1;
  localparam logic [1:0] CFG_MTVEC     = 2'd2;
  localparam logic [1:0] CFG_STVEC     = 2'd3;

  typedef struct packed {
    logic [63:0] pending_enabled;
    logic [1:0]  cur_priv;
    logic [63:0] status_in;
    logic [63:0] fault_pc;
    logic        exc_valid;
    logic [5:0]  exc_code;
    logic [63:0] exc_value;
  } in_item_t;

  typedef struct packed {
    logic        trap_taken;
    logic        to_super;
    logic [63:0] next_pc;
    logic [63:0] cause_out;
    logic [63:0] epc_out;
    logic [63:0] tval_out;
    logic [63:0] status_out;
    logic [1:0]  priv_out;
    logic        wake;
  } out_item_t;

  typedef struct packed {
    logic [63:0] int_delegation;
    logic [63:0] exc_delegation;
    logic [63:0] machine_vector;
    logic [63:0] super_vector;
  } cfg_t;

endpackage

// ===== hw/rtl/htu_in_if.sv =====
interface htu_in_if;
  logic              valid;
  logic              ready;
  htu_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/htu_out_if.sv =====
interface htu_out_if;
  logic               valid;
  logic               ready;
  htu_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/htu_decide.sv =====
module htu_decide (
  input  htu_pkg::in_item_t  item,
  input  htu_pkg::cfg_t      cfg,
  output htu_pkg::out_item_t res
);

  logic [63:0] usable;
  logic        m_en;
  logic        s_en;
  logic [63:0] m_cand;
  logic [63:0] cand;
  logic [63:0] local_bits;
  logic [5:0]  local_num;
  logic        int_hit;
  logic [5:0]  int_num;
  logic        is_int;
  logic        taken;
  logic [5:0]  num;
  logic [63:0] deleg;
  logic        to_s;
  logic [63:0] vec;
  logic [63:0] off;
  logic [63:0] st;

  assign usable = item.pending_enabled & (htu_pkg::LOCAL_MASK | htu_pkg::STD_IRQ_MASK);
  assign m_en   = (item.cur_priv == htu_pkg::PRIV_M) ? item.status_in[htu_pkg::MIE_BIT] : 1'b1;
  assign s_en   = ((item.cur_priv == htu_pkg::PRIV_S) && item.status_in[htu_pkg::SIE_BIT]) ||
                  (item.cur_priv == htu_pkg::PRIV_U);
  assign m_cand = m_en ? (usable & ~cfg.int_delegation) : '0;
  assign cand   = (m_cand != '0) ? m_cand : (s_en ? (usable & cfg.int_delegation) : '0);
  assign local_bits = cand & htu_pkg::LOCAL_MASK;

  always_comb begin
    local_num = '0;
    for (int i = 63; i >= int'(htu_pkg::LOCAL_IRQ_BASE); i--) begin
      if (local_bits[i]) begin
        local_num = 6'(i);
      end
    end
  end

  always_comb begin
    int_hit = 1'b1;
    int_num = '0;
    if (local_bits != '0) begin
      int_num = local_num;
    end else if (cand[htu_pkg::IRQ_MEI]) begin
      int_num = htu_pkg::IRQ_MEI;
    end else if (cand[htu_pkg::IRQ_MSI]) begin
      int_num = htu_pkg::IRQ_MSI;
    end else if (cand[htu_pkg::IRQ_MTI]) begin
      int_num = htu_pkg::IRQ_MTI;
    end else if (cand[htu_pkg::IRQ_SEI]) begin
      int_num = htu_pkg::IRQ_SEI;
    end else if (cand[htu_pkg::IRQ_SSI]) begin
      int_num = htu_pkg::IRQ_SSI;
    end else if (cand[htu_pkg::IRQ_STI]) begin
      int_num = htu_pkg::IRQ_STI;
    end else begin
      int_hit = 1'b0;
    end
  end

  assign is_int = int_hit;
  assign taken  = int_hit || item.exc_valid;
  assign num    = is_int ? int_num : item.exc_code;
  assign deleg  = is_int ? cfg.int_delegation : cfg.exc_delegation;
  assign to_s   = (item.cur_priv <= htu_pkg::PRIV_S) && deleg[num];
  assign vec    = to_s ? cfg.super_vector : cfg.machine_vector;
  assign off    = (is_int && vec[0]) ? {56'd0, num, 2'b00} : '0;

  always_comb begin
    st = item.status_in;
    if (to_s) begin
      st[htu_pkg::SPIE_BIT] = item.status_in[htu_pkg::SIE_BIT];
      st[htu_pkg::SPP_BIT]  = item.cur_priv[0];
      st[htu_pkg::SIE_BIT]  = 1'b0;
    end else begin
      st[htu_pkg::MPIE_BIT] = item.status_in[htu_pkg::MIE_BIT];
      st[htu_pkg::MPP_HI:htu_pkg::MPP_LO] = item.cur_priv;
      st[htu_pkg::MIE_BIT]  = 1'b0;
    end
  end

  always_comb begin
    res.wake = item.pending_enabled != '0;
    if (taken) begin
      res.trap_taken = 1'b1;
      res.to_super   = to_s;
      res.next_pc    = {vec[63:2], 2'b00} + off;
      res.cause_out  = {is_int, 57'd0, num};
      res.epc_out    = item.fault_pc;
      res.tval_out   = is_int ? '0 : item.exc_value;
      res.status_out = st;
      res.priv_out   = to_s ? htu_pkg::PRIV_S : htu_pkg::PRIV_M;
    end else begin
      res.trap_taken = 1'b0;
      res.to_super   = 1'b0;
      res.next_pc    = '0;
      res.cause_out  = '0;
      res.epc_out    = '0;
      res.tval_out   = '0;
      res.status_out = item.status_in;
      res.priv_out   = item.cur_priv;
    end
  end

endmodule

// ===== hw/rtl/hart_trap_entry_unit_core.sv =====
// Trap entry decision for one hart, one instruction step per item. Each item
// passes an input register, a single pass of decision logic (interrupt gating
// by mie/sie and mideleg, fixed priority pick, exception fallback, delegation,
// handler address and status update) and a result register: the result is
// offered once the item has moved from the input register into the result
// register, and a new item is accepted every cycle while the result side takes
// items. The user writes the delegation and vector registers through the cfg
// port only while no item is in flight; the block itself does not enforce this.
module hart_trap_entry_unit_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  htu_in_if.sink      in_chan,
  htu_out_if.source   out_chan
);

  htu_pkg::cfg_t      cfg_r;
  htu_pkg::in_item_t  s1_data_r;
  logic               s1_v_r;
  logic               s1_v_nxt;
  htu_pkg::out_item_t res;
  htu_pkg::out_item_t out_data_r;
  logic               out_v_r;
  logic               out_v_nxt;
  logic               adv;
  logic               in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        htu_pkg::CFG_INT_DELEG: cfg_r.int_delegation <= cfg_data;
        htu_pkg::CFG_EXC_DELEG: cfg_r.exc_delegation <= cfg_data;
        htu_pkg::CFG_MTVEC:     cfg_r.machine_vector <= cfg_data;
        htu_pkg::CFG_STVEC:     cfg_r.super_vector   <= cfg_data;
        default:                cfg_r <= cfg_r;
      endcase
    end
  end

  assign adv    = !out_v_r || out_chan.ready;
  assign in_rdy = !s1_v_r || adv;
  assign in_chan.ready = in_rdy;

  assign s1_v_nxt  = in_rdy ? in_chan.valid : s1_v_r;
  assign out_v_nxt = adv ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_chan.valid) begin
      s1_data_r <= in_chan.data;
    end
    if (adv && s1_v_r) begin
      out_data_r <= res;
    end
  end

  htu_decide u_decide (
    .item (s1_data_r),
    .cfg  (cfg_r),
    .res  (res)
  );

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_m_entry_priv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_data_r.trap_taken && !out_data_r.to_super) |->
      (out_data_r.priv_out == htu_pkg::PRIV_M && !out_data_r.status_out[htu_pkg::MIE_BIT]))
    else $error("machine trap entry left wrong privilege or MIE");

  a_s_entry_priv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_data_r.to_super) |->
      (out_data_r.trap_taken && out_data_r.priv_out == htu_pkg::PRIV_S &&
       !out_data_r.status_out[htu_pkg::SIE_BIT]))
    else $error("supervisor trap entry left wrong privilege or SIE");

  a_no_trap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_data_r.trap_taken) |->
      (out_data_r.cause_out == '0 && out_data_r.tval_out == '0 && out_data_r.next_pc == '0))
    else $error("no-trap result carries trap fields");

  a_int_needs_wake: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_data_r.trap_taken && out_data_r.cause_out[63]) |->
      (out_data_r.wake && out_data_r.tval_out == '0))
    else $error("interrupt trap without pending interrupt or with tval");

  a_pipe_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && adv) |=> out_v_r)
    else $error("item dropped between input and result register");
`endif

endmodule

// ===== sim/trap_entry_checker.sv =====
`timescale 1ns / 1ps

module trap_entry_checker
  import htu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  htu_in_if           in_chan,
  htu_out_if          out_chan,
  output int          fail_count,
  output int          results_due,
  output int          checked_count,
  output int          irq_count,
  output int          exc_count,
  output int          super_count
);

  localparam logic [5:0] IRQ_ORDER [6] = '{IRQ_MEI, IRQ_MSI, IRQ_MTI, IRQ_SEI, IRQ_SSI, IRQ_STI};

  cfg_t       regs;
  out_item_t  expected_traps [$];
  out_item_t  want;
  out_item_t  got;

  function automatic out_item_t predict_trap(in_item_t s, cfg_t c);
    logic [63:0] usable;
    logic [63:0] cand;
    logic [63:0] deleg;
    logic [63:0] vec;
    logic [63:0] offs;
    logic [63:0] st;
    logic        m_en;
    logic        s_en;
    logic        is_irq;
    logic        to_s;
    logic [5:0]  num;
    int          b;
    out_item_t   r;
    usable = s.pending_enabled & (LOCAL_MASK | STD_IRQ_MASK);
    m_en = (s.cur_priv == PRIV_M) ? s.status_in[MIE_BIT] : 1'b1;
    s_en = (s.cur_priv == PRIV_S) ? s.status_in[SIE_BIT] : (s.cur_priv == PRIV_U);
    cand = m_en ? (usable & ~c.int_delegation) : '0;
    if (cand == '0) begin
      cand = s_en ? (usable & c.int_delegation) : '0;
    end
    is_irq = 1'b0;
    num = '0;
    if ((cand & LOCAL_MASK) != '0) begin
      for (b = 63; b >= LOCAL_IRQ_BASE; b--) begin
        if (cand[b]) num = 6'(b);
      end
      is_irq = 1'b1;
    end else begin
      for (b = 5; b >= 0; b--) begin
        if (cand[IRQ_ORDER[b]]) begin
          num = IRQ_ORDER[b];
          is_irq = 1'b1;
        end
      end
    end
    r = '0;
    r.wake = |s.pending_enabled;
    r.status_out = s.status_in;
    r.priv_out = s.cur_priv;
    if (is_irq || s.exc_valid) begin
      if (!is_irq) num = s.exc_code;
      deleg = is_irq ? c.int_delegation : c.exc_delegation;
      to_s = (s.cur_priv <= PRIV_S) && deleg[num];
      vec = to_s ? c.super_vector : c.machine_vector;
      offs = (is_irq && vec[0]) ? {56'd0, num, 2'b00} : '0;
      st = s.status_in;
      if (to_s) begin
        st[SPIE_BIT] = st[SIE_BIT];
        st[SPP_BIT] = s.cur_priv[0];
        st[SIE_BIT] = 1'b0;
      end else begin
        st[MPIE_BIT] = st[MIE_BIT];
        st[MPP_HI:MPP_LO] = s.cur_priv;
        st[MIE_BIT] = 1'b0;
      end
      r.trap_taken = 1'b1;
      r.to_super = to_s;
      r.next_pc = (vec & ~64'd3) + offs;
      r.cause_out = {is_irq, 57'd0, num};
      r.epc_out = s.fault_pc;
      r.tval_out = is_irq ? '0 : s.exc_value;
      r.status_out = st;
      r.priv_out = to_s ? PRIV_S : PRIV_M;
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] result %0d: %s", $time, checked_count, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [63:0] actual, logic [63:0] ideal);
    if (actual !== ideal) begin
      report_mismatch($sformatf("%s got %h want %h", name, actual, ideal));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      regs <= '0;
      expected_traps.delete();
      results_due <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INT_DELEG: regs.int_delegation <= cfg_data;
          CFG_EXC_DELEG: regs.exc_delegation <= cfg_data;
          CFG_MTVEC:     regs.machine_vector <= cfg_data;
          CFG_STVEC:     regs.super_vector <= cfg_data;
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        expected_traps.push_back(predict_trap(in_chan.data, regs));
      end
      if (out_chan.valid && out_chan.ready) begin
        got = out_chan.data;
        if (expected_traps.size() == 0) begin
          report_mismatch($sformatf("unexpected item %h", got));
        end else begin
          want = expected_traps.pop_front();
          check_field("trap_taken", 64'(got.trap_taken), 64'(want.trap_taken));
          check_field("to_super", 64'(got.to_super), 64'(want.to_super));
          check_field("next_pc", got.next_pc, want.next_pc);
          check_field("cause_out", got.cause_out, want.cause_out);
          check_field("epc_out", got.epc_out, want.epc_out);
          check_field("tval_out", got.tval_out, want.tval_out);
          check_field("status_out", got.status_out, want.status_out);
          check_field("priv_out", 64'(got.priv_out), 64'(want.priv_out));
          check_field("wake", 64'(got.wake), 64'(want.wake));
          if (want.trap_taken) begin
            if (want.cause_out[63]) irq_count++;
            else exc_count++;
            if (want.to_super) super_count++;
          end
        end
        checked_count++;
      end
      results_due <= expected_traps.size();
    end
  end

endmodule

// ===== sim/hart_trap_entry_unit_core_tb.sv =====
`timescale 1ns / 1ps

module hart_trap_entry_unit_core_tb;
  import htu_pkg::*;

  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [1:0] PRIV_RSVD = 2'd2;
  localparam logic [5:0] STD_IRQS [6] = '{IRQ_SSI, IRQ_MSI, IRQ_STI, IRQ_MTI, IRQ_SEI, IRQ_MEI};

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  bit          stall_en;
  int          cycle_count;
  int          setting_count;
  int          fail_count;
  int          results_due;
  int          checked_count;
  int          irq_count;
  int          exc_count;
  int          super_count;

  htu_in_if  in_chan();
  htu_out_if out_chan();

  hart_trap_entry_unit_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  trap_entry_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .checked_count(checked_count),
    .irq_count    (irq_count),
    .exc_count    (exc_count),
    .super_count  (super_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("hart_trap_entry_unit_core test failed");
      $finish;
    end else begin
      cycle_count <= cycle_count + 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t random_step();
    in_item_t    s;
    logic [63:0] pend;
    case ($urandom_range(0, 9))
      0:       pend = '0;
      1, 2:    pend = 64'd1 << STD_IRQS[$urandom_range(0, 5)];
      3:       pend = rand64() & ~LOCAL_MASK;
      4:       pend = (64'd1 << $urandom_range(LOCAL_IRQ_BASE, 63)) | (rand64() & ~LOCAL_MASK);
      5:       pend = rand64() & ~LOCAL_MASK & ~STD_IRQ_MASK;
      default: pend = rand64() & ($urandom_range(0, 1) ? rand64() : '1);
    endcase
    s.pending_enabled = pend;
    s.cur_priv = 2'($urandom_range(0, 3));
    s.status_in = rand64();
    s.fault_pc = rand64();
    s.exc_valid = 1'($urandom_range(0, 1));
    s.exc_code = 6'($urandom_range(0, 63));
    s.exc_value = rand64();
    return s;
  endfunction

  task automatic send_item(in_item_t s);
    if (stall_en && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data <= s;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic step(logic [63:0] pend, logic [1:0] priv, logic [63:0] status,
                      logic [63:0] pc, logic excv, logic [5:0] code, logic [63:0] val);
    in_item_t s;
    s = '{pend, priv, status, pc, excv, code, val};
    send_item(s);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_regs(cfg_t c);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INT_DELEG;
    cfg_data <= c.int_delegation;
    @(posedge clk);
    cfg_index <= CFG_EXC_DELEG;
    cfg_data <= c.exc_delegation;
    @(posedge clk);
    cfg_index <= CFG_MTVEC;
    cfg_data <= c.machine_vector;
    @(posedge clk);
    cfg_index <= CFG_STVEC;
    cfg_data <= c.super_vector;
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  task automatic random_phase(cfg_t c, int count, bit idle);
    stall_en = idle;
    write_regs(c);
    repeat (count) send_item(random_step());
    drain();
  endtask

  initial begin
    out_chan.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_en && $urandom_range(0, 2) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.data = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_INT_DELEG;
    cfg_data = '0;
    rst_n = 1'b0;
    stall_en = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_regs('{64'h0000_0000_0002_0222, 64'h8000_0000_0000_B1FF,
                 64'h8000_0000_0000_1001, 64'h0000_0000_8000_0003});
    step('0, PRIV_M, '0, 64'h1000, 1'b0, 6'd0, '0);
    step(64'hF555, PRIV_U, '0, 64'h1004, 1'b0, 6'd0, 64'h55);
    step(64'hF557, PRIV_S, 64'h2, 64'h1008, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_MEI, PRIV_U, '0, 64'h100c, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_MSI, PRIV_U, '0, 64'h1010, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_MTI, PRIV_U, '0, 64'h1014, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_SEI, PRIV_U, '0, 64'h1018, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_SSI, PRIV_U, '0, 64'h101c, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_STI, PRIV_U, '0, 64'h1020, 1'b1, 6'd2, 64'h77);
    step(STD_IRQ_MASK, PRIV_M, 64'h8, 64'h1024, 1'b0, 6'd0, '0);
    step(STD_IRQ_MASK, PRIV_M, 64'h1800, 64'h1028, 1'b1, 6'd2, 64'hdead);
    step(STD_IRQ_MASK | (64'd1 << 16), PRIV_U, '0, 64'h102c, 1'b0, 6'd0, '0);
    step(64'd1 << 63, PRIV_S, '0, 64'h1030, 1'b0, 6'd0, '0);
    step(64'd1 << 17, PRIV_S, 64'h2, 64'h1034, 1'b0, 6'd0, '0);
    step(64'd1 << 17, PRIV_S, '0, 64'h1038, 1'b1, 6'd8, 64'h88);
    step(64'd1 << IRQ_SEI, PRIV_RSVD, 64'hA, 64'h103c, 1'b0, 6'd0, '0);
    step(64'd1 << IRQ_MTI, PRIV_RSVD, '0, 64'h1040, 1'b0, 6'd0, '0);
    step('0, PRIV_RSVD, 64'h2, 64'h1044, 1'b1, 6'd1, 64'h11);
    step('0, PRIV_U, 64'h2, 64'h1048, 1'b1, 6'd0, 64'h1);
    step('0, PRIV_S, 64'h122, 64'h104c, 1'b1, 6'd63, 64'h3f);
    step('0, PRIV_M, '0, 64'h1050, 1'b1, 6'd63, 64'h3f);
    step('1, PRIV_M, '1, '1, 1'b1, 6'd63, '1);
    step('1, PRIV_U, '0, '1, 1'b0, 6'd0, '1);
    step('0, PRIV_U, '1, '1, 1'b1, 6'd12, '1);
    drain();

    random_phase('0, 250, 1'b1);
    random_phase('1, 250, 1'b1);
    random_phase('{rand64(), rand64(), rand64() | 64'd1, rand64() | 64'd1}, 300, 1'b1);
    random_phase('{rand64(), rand64(), rand64(), rand64()}, 300, 1'b1);
    random_phase('{64'h222 | (rand64() & LOCAL_MASK), rand64(), '1,
                   64'hFFFF_FFFF_FFFF_FF01}, 250, 1'b1);
    random_phase('{rand64(), rand64(), rand64(), rand64()}, 250, 1'b0);

    repeat (10) @(posedge clk);
    $display("checked %0d trap decisions under %0d register settings", checked_count,
             setting_count);
    $display("traps entered: %0d interrupt, %0d exception, %0d into S mode", irq_count,
             exc_count, super_count);
    if (fail_count == 0) begin
      $display("hart_trap_entry_unit_core test passed");
    end else begin
      $display("hart_trap_entry_unit_core test failed");
    end
    $finish;
  end

endmodule
